/* hw/rtl/brcf_pkg.sv */
// Shared constants, codes and control types of the byte ring chunk FIFO.
`default_nettype none
package brcf_pkg;

    localparam int DEPTH     = 4096;
    localparam int MAX_CHUNK = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int LEN_W     = 7;
    localparam int DATA_W    = 8;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } brcf_action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_DATA  = 2'd1,
        STAT_NO_SPACE = 2'd2
    } brcf_status_t;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } brcf_state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic start;
        logic issue;
    } brcf_cmd_t;

    typedef struct packed {
        logic pipe_idle;
        logic rd_slot_free;
        logic req_stream;
        logic last_read;
    } brcf_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/brcf_ctrl.sv */
// Controller state machine that sequences requests and chunk read-out.
`default_nettype none
module brcf_ctrl
    import brcf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    input  wire brcf_stat_t stat,
    output brcf_cmd_t       cmd
);

    brcf_state_t state_reg;
    brcf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.ready  = stat.pipe_idle;
                cmd.accept = stat.pipe_idle && s_axis_tvalid;
                cmd.start  = stat.pipe_idle && s_axis_tvalid && stat.req_stream;
            end
            ST_STREAM: begin
                cmd.issue = stat.rd_slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.pipe_idle && s_axis_tvalid && stat.req_stream) begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (stat.rd_slot_free && stat.last_read) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/brcf_dp.sv */
// Datapath with ring pointers, byte store, read pipeline and output register.
`default_nettype none
module brcf_dp
    import brcf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [SIZE_W-1:0]    cfg_wr_data,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [ACT_W-1:0]     s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic                      m_axis_tlast,
    input  wire brcf_cmd_t            cmd,
    output brcf_stat_t                stat
);

    logic [DATA_W-1:0] byte_store [DEPTH];

    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic              full_reg, full_next;
    logic [LEN_W-1:0]  push_cnt_reg, push_cnt_next;
    logic              push_acc_reg, push_acc_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              p1_valid_reg, p1_valid_next;
    logic              m_valid_reg, m_valid_next;

    logic [LEN_W-1:0]  len_reg;
    logic [SIZE_W-1:0] freesp_reg;
    logic [DATA_W-1:0] mem_rdata_reg;
    logic              p1_last_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [LEN_W-1:0]  out_cnt_reg;
    logic [SIZE_W-1:0] out_free_reg;
    logic              out_last_reg;

    brcf_action_t      action;
    logic [LEN_W-1:0]  len_in;
    logic [LEN_W-1:0]  len_eff;
    logic [DATA_W-1:0] data_in;
    logic [SIZE_W-1:0] len_ext;
    logic [SIZE_W-1:0] rp_ext;
    logic [SIZE_W-1:0] wp_ext;
    logic [SIZE_W-1:0] free_now;
    logic [SIZE_W-1:0] stored;
    logic              stream_ok;
    logic              push_acc;
    logic              push_wr;
    logic [SIZE_W-1:0] wp_plus1;
    logic [SIZE_W-1:0] wp_inc;
    logic [LEN_W-1:0]  push_cnt_inc;
    logic              push_done;
    logic [SIZE_W-1:0] rp_plus_len;
    logic [SIZE_W-1:0] rp_adv;
    logic [SIZE_W-1:0] ra_plus1;
    logic [SIZE_W-1:0] ra_inc;
    logic              out_free;
    logic              p1_move;
    logic              res_load;
    logic [STAT_W-1:0] res_stat;
    logic [LEN_W-1:0]  res_cnt;
    logic [SIZE_W-1:0] res_free;
    logic [SIZE_W-1:0] cfg_size;

    assign action  = brcf_action_t'(s_axis_tuser);
    assign len_in  = s_axis_tdata[LEN_W-1:0];
    assign data_in = s_axis_tdata[LEN_W +: DATA_W];

    always_comb begin
        if (len_in == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_in > LEN_W'(MAX_CHUNK)) begin
            len_eff = LEN_W'(MAX_CHUNK);
        end else begin
            len_eff = len_in;
        end
    end

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_size = SIZE_W'(1);
        end else if (cfg_wr_data > SIZE_W'(DEPTH)) begin
            cfg_size = SIZE_W'(DEPTH);
        end else begin
            cfg_size = cfg_wr_data;
        end
    end

    assign len_ext = SIZE_W'(len_eff);
    assign rp_ext  = {1'b0, rd_ptr_reg};
    assign wp_ext  = {1'b0, wr_ptr_reg};

    always_comb begin
        if (full_reg) begin
            free_now = '0;
        end else if (wr_ptr_reg == rd_ptr_reg) begin
            free_now = sz_reg;
        end else if (rd_ptr_reg > wr_ptr_reg) begin
            free_now = rp_ext - wp_ext;
        end else begin
            free_now = rp_ext + sz_reg - wp_ext;
        end
    end

    assign stored    = sz_reg - free_now;
    assign stream_ok = stored >= len_ext;

    assign push_acc     = (push_cnt_reg == '0) ? (free_now >= len_ext) : push_acc_reg;
    assign push_wr      = push_acc && !full_reg;
    assign wp_plus1     = wp_ext + SIZE_W'(1);
    assign wp_inc       = (wp_plus1 == sz_reg) ? '0 : wp_plus1;
    assign push_cnt_inc = push_cnt_reg + LEN_W'(1);
    assign push_done    = push_cnt_inc >= len_eff;

    assign rp_plus_len = rp_ext + len_ext;
    assign rp_adv      = (rp_plus_len >= sz_reg) ? rp_plus_len - sz_reg : rp_plus_len;
    assign ra_plus1    = {1'b0, rd_addr_reg} + SIZE_W'(1);
    assign ra_inc      = (ra_plus1 == sz_reg) ? '0 : ra_plus1;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign p1_move  = p1_valid_reg && out_free;

    assign stat.pipe_idle    = !p1_valid_reg && out_free;
    assign stat.rd_slot_free = !p1_valid_reg || out_free;
    assign stat.req_stream   = (action == ACT_POP || action == ACT_PEEK) && stream_ok;
    assign stat.last_read    = rem_reg == LEN_W'(1);

    always_comb begin
        sz_next       = sz_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        full_next     = full_reg;
        push_cnt_next = push_cnt_reg;
        push_acc_next = push_acc_reg;
        rd_addr_next  = rd_addr_reg;
        rem_next      = rem_reg;
        res_load      = 1'b0;
        res_stat      = STAT_OK;
        res_cnt       = '0;
        res_free      = free_now;

        if (cmd.accept) begin
            case (action)
                ACT_PUSH: begin
                    if (push_wr) begin
                        wr_ptr_next = wp_inc[ADDR_W-1:0];
                        if (wp_inc[ADDR_W-1:0] == rd_ptr_reg) begin
                            full_next = 1'b1;
                        end
                    end
                    if (push_done) begin
                        push_cnt_next = '0;
                        push_acc_next = 1'b0;
                        res_load      = 1'b1;
                        res_stat      = push_acc ? STAT_OK : STAT_NO_SPACE;
                        res_cnt       = push_acc ? push_cnt_inc : '0;
                        res_free      = push_wr ? free_now - SIZE_W'(1) : free_now;
                    end else begin
                        push_cnt_next = push_cnt_inc;
                        push_acc_next = push_acc;
                    end
                end
                ACT_POP, ACT_PEEK: begin
                    if (stream_ok) begin
                        rd_addr_next = rd_ptr_reg;
                        rem_next     = len_eff;
                        if (action == ACT_POP) begin
                            rd_ptr_next = rp_adv[ADDR_W-1:0];
                            full_next   = 1'b0;
                        end
                    end else begin
                        res_load = 1'b1;
                        res_stat = STAT_NO_DATA;
                    end
                end
                ACT_CLEAR: begin
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    full_next     = 1'b0;
                    push_cnt_next = '0;
                    push_acc_next = 1'b0;
                    res_load      = 1'b1;
                    res_free      = sz_reg;
                end
                default: begin
                    res_load = 1'b0;
                end
            endcase
        end

        if (cmd.issue) begin
            rd_addr_next = ra_inc[ADDR_W-1:0];
            rem_next     = rem_reg - LEN_W'(1);
        end

        if (cfg_wr_en) begin
            sz_next       = cfg_size;
            rd_ptr_next   = '0;
            wr_ptr_next   = '0;
            full_next     = 1'b0;
            push_cnt_next = '0;
            push_acc_next = 1'b0;
        end
    end

    always_comb begin
        if (cmd.issue) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end

        if (p1_move || res_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sz_reg       <= SIZE_W'(DEPTH);
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            full_reg     <= 1'b0;
            push_cnt_reg <= '0;
            push_acc_reg <= 1'b0;
            rd_addr_reg  <= '0;
            rem_reg      <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            sz_reg       <= sz_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            full_reg     <= full_next;
            push_cnt_reg <= push_cnt_next;
            push_acc_reg <= push_acc_next;
            rd_addr_reg  <= rd_addr_next;
            rem_reg      <= rem_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && action == ACT_PUSH && push_wr) begin
            byte_store[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            mem_rdata_reg <= byte_store[rd_addr_reg];
            p1_last_reg   <= rem_reg == LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            len_reg    <= len_eff;
            freesp_reg <= (action == ACT_POP) ? free_now + len_ext : free_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            out_data_reg <= mem_rdata_reg;
            out_stat_reg <= STAT_OK;
            out_cnt_reg  <= len_reg;
            out_free_reg <= freesp_reg;
            out_last_reg <= p1_last_reg;
        end else if (res_load) begin
            out_data_reg <= '0;
            out_stat_reg <= res_stat;
            out_cnt_reg  <= res_cnt;
            out_free_reg <= res_free;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_free_reg, out_cnt_reg, out_stat_reg, out_data_reg});

    a_full_means_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> wr_ptr_reg == rd_ptr_reg)
        else $error("Full flag set while the pointers differ.");

    a_rd_ptr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        rp_ext < sz_reg)
        else $error("Read pointer outside the ring.");

    a_wr_ptr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_ext < sz_reg)
        else $error("Write pointer outside the ring.");

    a_no_read_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> rem_reg != '0)
        else $error("Read issued with no bytes left in the chunk.");

endmodule
`default_nettype wire

/* hw/rtl/byte_ring_chunk_fifo.sv */
// Top level of the byte ring chunk FIFO: controller plus datapath.
//
// Chunk-atomic byte ring of up to 4096 slots. Push, clear and failed pop or
// peek requests are accepted one transaction per cycle when the output side keeps up.
// A successful pop or peek of L bytes holds the input while its bytes are read:
// the byte store has one registered read port, so each byte passes through the
// read register and then the output register, one byte per cycle while the
// output side keeps up. The byte store needs no clearing pass after reset.
`default_nettype none
module byte_ring_chunk_fifo
    import brcf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [SIZE_W-1:0]    cfg_wr_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // length[6:0], data_in[14:7]
    input  wire logic [ACT_W-1:0]     s_axis_tuser,  // action[1:0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // data_out, status, count, free_space
    output logic                      m_axis_tlast
);

    brcf_cmd_t  cmd;
    brcf_stat_t stat;

    brcf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .stat          (stat),
        .cmd           (cmd)
    );

    brcf_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign s_axis_tready = cmd.ready;

endmodule
`default_nettype wire
